[hdl/pswb_pkg.sv]
// shared widths, register indexes and reset values for the particle integrator
package pswb_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int ARENA_W    = 12;
   localparam int MASS_W     = 17;
   localparam int MASS_FRAC  = 16;
   localparam int LIMIT_W    = 16;
   localparam int FORCE_W    = 17;
   localparam int POS_W      = 20;
   localparam int VEL_W      = 17;
   localparam int ACC_W      = 24;
   localparam int VSUM_W     = ACC_W + 1;
   localparam int MAG_W      = ACC_W;
   localparam int MUL_W      = MAG_W;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ROOT_W     = MAG_W + 1;
   localparam int SQ_W       = 2 * ROOT_W;
   localparam int QUOT_W     = LIMIT_W;
   localparam int DIVN_W     = MAG_W + LIMIT_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = MASS_W;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_ARENA_WIDTH  = 2'd0;
   localparam csr_index_type REG_ARENA_HEIGHT = 2'd1;
   localparam csr_index_type REG_INVERSE_MASS = 2'd2;
   localparam csr_index_type REG_SPEED_LIMIT  = 2'd3;

   localparam logic OP_FORCE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [ARENA_W-1:0] ARENA_WIDTH_RESET  = 12'd1024;
   localparam logic [ARENA_W-1:0] ARENA_HEIGHT_RESET = 12'd768;
   localparam logic [MASS_W-1:0]  INVERSE_MASS_RESET = 17'd65536;
   localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET  = 16'd2560;

endpackage

[hdl/pswb_mul_serial.sv]
// unsigned shift-add multiplier, one multiplier bit per cycle
module pswb_mul_serial #(
   parameter int A_W = pswb_pkg::MUL_W,
   parameter int B_W = pswb_pkg::MUL_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               busy,
   output logic [A_W+B_W-1:0] product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic               busy_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [A_W-1:0]     a_ff;
   logic [A_W+B_W-1:0] prod_ff;
   logic [A_W:0]       partial;

   // upper half accumulates, lower half holds the multiplier bits still to go
   assign partial = {1'b0, prod_ff[A_W+B_W-1:B_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(B_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= a;
         prod_ff <= {{A_W{1'b0}}, b};
      end else if (busy_ff) begin
         prod_ff <= {partial, prod_ff[B_W-1:1]};
      end
   end

   assign busy    = busy_ff;
   assign product = prod_ff;

endmodule

[hdl/pswb_div_serial.sv]
// restoring divider, one quotient bit per cycle
module pswb_div_serial #(
   parameter int N_W = pswb_pkg::DIVN_W,
   parameter int D_W = pswb_pkg::ROOT_W,
   parameter int Q_W = pswb_pkg::QUOT_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] n,
   input  logic [D_W-1:0] d,
   output logic           busy,
   output logic [Q_W-1:0] quotient
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [D_W-1:0]   rem_ff;
   logic [D_W-1:0]   d_ff;
   logic [Q_W-1:0]   quo_ff;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[Q_W-1]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(Q_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // the quotient must fit Q_W bits, so the dividend's upper part starts below d
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= D_W'(n[N_W-1:Q_W]);
         quo_ff <= n[Q_W-1:0];
         d_ff   <= d;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
         quo_ff <= {quo_ff[Q_W-2:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[hdl/particle_step_with_wall_bounce_core.sv]
// particle integrator top level: state, sequencer, serial root and wall bounce
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   req_operation, req_force_x, req_force_y
//   rsp       out   rsp_valid/rsp_stall   rsp_pos_x/y, rsp_vel_x/y, rsp_bounced_x/y
//   csr       in    csr_wr_en             csr_index, csr_wdata
//
// the serial multipliers (squares, then speed times limit), the 25-step square root
// and the 16-step divider set how long a request takes: a force request uses only the
// multipliers, a tick also the root, and a tick whose speed gets capped the divider as well
// one request is in flight at a time; req_stall is high whenever the sequencer is busy
// a finished tick waits in the result register; the next tick stops before its
// last step while rsp_stall holds the previous result
// reset is synchronous and returns registers and particle state to their reset values
module particle_step_with_wall_bounce_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_operation,
   input  logic signed [pswb_pkg::FORCE_W-1:0]     req_force_x,
   input  logic signed [pswb_pkg::FORCE_W-1:0]     req_force_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic        [pswb_pkg::POS_W-1:0]       rsp_pos_x,
   output logic        [pswb_pkg::POS_W-1:0]       rsp_pos_y,
   output logic signed [pswb_pkg::VEL_W-1:0]       rsp_vel_x,
   output logic signed [pswb_pkg::VEL_W-1:0]       rsp_vel_y,
   output logic                                    rsp_bounced_x,
   output logic                                    rsp_bounced_y,
   input  logic                                    csr_wr_en,
   input  logic        [pswb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [pswb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import pswb_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_FORCE  = 3'd1;
   localparam logic [ST_W-1:0] ST_SUM    = 3'd2;
   localparam logic [ST_W-1:0] ST_SQUARE = 3'd3;
   localparam logic [ST_W-1:0] ST_ROOT   = 3'd4;
   localparam logic [ST_W-1:0] ST_DIVIDE = 3'd5;
   localparam logic [ST_W-1:0] ST_MOVE   = 3'd6;

   localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
   localparam logic [PROD_W-1:0] MASS_ROUND = PROD_W'((64'd1 << MASS_FRAC) - 64'd1);
   localparam logic [ACC_W-1:0]  ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0]  ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [POS_W-1:0]  POS_MAX    = '1;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [VEL_W-1:0] vel;
      logic             bounced;
   } axis_type;

   function automatic logic [POS_W-1:0] edge_of(logic [ARENA_W-1:0] arena_size);
      logic [31:0] wide;
      wide = 32'(arena_size) << FRAC_BITS;
      if (wide > 32'(POS_MAX)) begin
         return POS_MAX;
      end
      return wide[POS_W-1:0];
   endfunction

   // floor of force * inverse mass / 2^16, added with saturation
   function automatic logic signed [ACC_W-1:0] add_force(logic signed [ACC_W-1:0] acc,
                                                         logic [PROD_W-1:0] prod,
                                                         logic neg);
      logic [PROD_W-1:0] biased;
      logic [ACC_W+1:0]  delta;
      logic [ACC_W+1:0]  sum;
      biased = prod + (neg ? MASS_ROUND : '0);
      delta  = (ACC_W+2)'(biased[PROD_W-1:MASS_FRAC]);
      if (neg) begin
         delta = -delta;
      end
      sum = {acc[ACC_W-1], acc[ACC_W-1], acc} + delta;
      if (sum[ACC_W+1:ACC_W-1] == 3'b000 || sum[ACC_W+1:ACC_W-1] == 3'b111) begin
         return $signed(sum[ACC_W-1:0]);
      end
      return sum[ACC_W+1] ? $signed(ACC_MIN) : $signed(ACC_MAX);
   endfunction

   function automatic logic signed [VEL_W-1:0] apply_sign(logic [VEL_W-1:0] m, logic neg);
      logic [VEL_W-1:0] r;
      r = neg ? -m : m;
      return $signed(r);
   endfunction

   function automatic axis_type move_axis(logic [POS_W-1:0] pos,
                                          logic signed [VEL_W-1:0] vel,
                                          logic [POS_W-1:0] edge_pos);
      logic signed [POS_W+1:0] p;
      axis_type r;
      p = $signed({2'b00, pos}) + (POS_W+2)'(vel);
      r.vel     = vel;
      r.bounced = 1'b0;
      r.pos     = p[POS_W-1:0];
      if (p > $signed({2'b00, edge_pos})) begin
         r.pos     = edge_pos;
         r.vel     = -vel;
         r.bounced = 1'b1;
      end else if (p[POS_W+1]) begin
         r.pos     = '0;
         r.vel     = -vel;
         r.bounced = 1'b1;
      end
      return r;
   endfunction

   // control and particle state
   logic [ST_W-1:0]          state_ff;
   logic                     rsp_valid_ff;
   logic [ARENA_W-1:0]       arena_width_ff;
   logic [ARENA_W-1:0]       arena_height_ff;
   logic [MASS_W-1:0]        inverse_mass_ff;
   logic [LIMIT_W-1:0]       speed_limit_ff;
   logic [POS_W-1:0]         pos_x_ff;
   logic [POS_W-1:0]         pos_y_ff;
   logic signed [VEL_W-1:0]  vel_x_ff;
   logic signed [VEL_W-1:0]  vel_y_ff;
   logic signed [ACC_W-1:0]  acc_x_ff;
   logic signed [ACC_W-1:0]  acc_y_ff;
   logic [ROOT_CNT_W-1:0]    root_cnt_ff;

   // datapath
   logic                     neg_x_ff;
   logic                     neg_y_ff;
   logic [MAG_W-1:0]         mag_x_ff;
   logic [MAG_W-1:0]         mag_y_ff;
   logic [SQ_W-1:0]          rad_ff;
   logic [ROOT_W:0]          rem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic signed [VEL_W-1:0]  vnew_x_ff;
   logic signed [VEL_W-1:0]  vnew_y_ff;
   logic                     bounced_x_ff;
   logic                     bounced_y_ff;

   logic                     req_fire;
   logic                     rsp_free;
   logic [FORCE_W-1:0]       fmag_x;
   logic [FORCE_W-1:0]       fmag_y;
   logic signed [VSUM_W-1:0] vsum_x;
   logic signed [VSUM_W-1:0] vsum_y;
   logic [MAG_W-1:0]         mag_comb_x;
   logic [MAG_W-1:0]         mag_comb_y;
   logic [ROOT_W+2:0]        root_cur;
   logic [ROOT_W+2:0]        root_trial;
   logic [ROOT_W+2:0]        root_diff;
   logic                     root_fits;
   logic                     root_cap;
   logic                     root_done;
   axis_type                 move_x;
   axis_type                 move_y;

   logic                     mul_start;
   logic [MUL_W-1:0]         mul_a_x;
   logic [MUL_W-1:0]         mul_a_y;
   logic [MUL_W-1:0]         mul_b_x;
   logic [MUL_W-1:0]         mul_b_y;
   logic                     mul_busy_x;
   logic                     mul_busy_y;
   logic [PROD_W-1:0]        prod_x;
   logic [PROD_W-1:0]        prod_y;
   logic                     div_start;
   logic                     div_busy_x;
   logic                     div_busy_y;
   logic [QUOT_W-1:0]        quot_x;
   logic [QUOT_W-1:0]        quot_y;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign fmag_x = req_force_x[FORCE_W-1] ? $unsigned(-req_force_x) : $unsigned(req_force_x);
   assign fmag_y = req_force_y[FORCE_W-1] ? $unsigned(-req_force_y) : $unsigned(req_force_y);

   assign vsum_x     = VSUM_W'(vel_x_ff) + VSUM_W'(acc_x_ff);
   assign vsum_y     = VSUM_W'(vel_y_ff) + VSUM_W'(acc_y_ff);
   assign mag_comb_x = vsum_x[VSUM_W-1] ? MAG_W'(-vsum_x) : MAG_W'(vsum_x);
   assign mag_comb_y = vsum_y[VSUM_W-1] ? MAG_W'(-vsum_y) : MAG_W'(vsum_y);

   // digit-by-digit root: two radicand bits come down per step
   assign root_cur   = {rem_ff, rad_ff[SQ_W-1:SQ_W-2]};
   assign root_trial = (ROOT_W+3)'({root_ff, 2'b01});
   assign root_diff  = root_cur - root_trial;
   assign root_fits  = root_cur >= root_trial;
   assign root_done  = (root_cnt_ff == '0) && !mul_busy_x;
   // a root equal to the limit leaves the velocity unchanged, so only a larger one caps
   assign root_cap   = root_ff > ROOT_W'(speed_limit_ff);

   assign move_x = move_axis(pos_x_ff, vnew_x_ff, edge_of(arena_width_ff));
   assign move_y = move_axis(pos_y_ff, vnew_y_ff, edge_of(arena_height_ff));

   always_comb begin
      mul_start = 1'b0;
      mul_a_x   = mag_comb_x;
      mul_a_y   = mag_comb_y;
      mul_b_x   = mag_comb_x;
      mul_b_y   = mag_comb_y;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_operation == OP_FORCE) begin
               mul_start = 1'b1;
               mul_a_x   = MUL_W'(fmag_x);
               mul_a_y   = MUL_W'(fmag_y);
               mul_b_x   = MUL_W'(inverse_mass_ff);
               mul_b_y   = MUL_W'(inverse_mass_ff);
            end
         end
         ST_SUM: begin
            mul_start = 1'b1;
         end
         ST_SQUARE: begin
            // speed times limit runs beside the root
            mul_start = !mul_busy_x;
            mul_a_x   = mag_x_ff;
            mul_a_y   = mag_y_ff;
            mul_b_x   = MUL_W'(speed_limit_ff);
            mul_b_y   = MUL_W'(speed_limit_ff);
         end
         default: begin
         end
      endcase
   end

   assign div_start = (state_ff == ST_ROOT) && root_done && root_cap;

   pswb_mul_serial #(.A_W(MUL_W), .B_W(MUL_W)) u_mul_x (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a_x),
      .b       (mul_b_x),
      .busy    (mul_busy_x),
      .product (prod_x)
   );

   pswb_mul_serial #(.A_W(MUL_W), .B_W(MUL_W)) u_mul_y (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a_y),
      .b       (mul_b_y),
      .busy    (mul_busy_y),
      .product (prod_y)
   );

   pswb_div_serial #(.N_W(DIVN_W), .D_W(ROOT_W), .Q_W(QUOT_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .n        (prod_x[DIVN_W-1:0]),
      .d        (root_ff),
      .busy     (div_busy_x),
      .quotient (quot_x)
   );

   pswb_div_serial #(.N_W(DIVN_W), .D_W(ROOT_W), .Q_W(QUOT_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .n        (prod_y[DIVN_W-1:0]),
      .d        (root_ff),
      .busy     (div_busy_y),
      .quotient (quot_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         arena_width_ff  <= ARENA_WIDTH_RESET;
         arena_height_ff <= ARENA_HEIGHT_RESET;
         inverse_mass_ff <= INVERSE_MASS_RESET;
         speed_limit_ff  <= SPEED_LIMIT_RESET;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
         vel_x_ff        <= '0;
         vel_y_ff        <= '0;
         acc_x_ff        <= '0;
         acc_y_ff        <= '0;
         root_cnt_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ARENA_WIDTH:  arena_width_ff  <= csr_wdata[ARENA_W-1:0];
               REG_ARENA_HEIGHT: arena_height_ff <= csr_wdata[ARENA_W-1:0];
               REG_INVERSE_MASS: inverse_mass_ff <= csr_wdata[MASS_W-1:0];
               REG_SPEED_LIMIT:  speed_limit_ff  <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end

         if (state_ff == ST_MOVE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= (req_operation == OP_TICK) ? ST_SUM : ST_FORCE;
               end
            end
            ST_FORCE: begin
               if (!mul_busy_x) begin
                  acc_x_ff <= add_force(acc_x_ff, prod_x, neg_x_ff);
                  acc_y_ff <= add_force(acc_y_ff, prod_y, neg_y_ff);
                  state_ff <= ST_IDLE;
               end
            end
            ST_SUM: begin
               state_ff <= ST_SQUARE;
            end
            ST_SQUARE: begin
               if (!mul_busy_x) begin
                  root_cnt_ff <= ROOT_CNT_W'(ROOT_W);
                  state_ff    <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_cnt_ff != '0) begin
                  root_cnt_ff <= root_cnt_ff - ROOT_CNT_W'(1);
               end else if (root_done) begin
                  state_ff <= root_cap ? ST_DIVIDE : ST_MOVE;
               end
            end
            ST_DIVIDE: begin
               if (!div_busy_x) begin
                  state_ff <= ST_MOVE;
               end
            end
            ST_MOVE: begin
               if (rsp_free) begin
                  pos_x_ff     <= move_x.pos;
                  pos_y_ff     <= move_y.pos;
                  vel_x_ff     <= $signed(move_x.vel);
                  vel_y_ff     <= $signed(move_y.vel);
                  acc_x_ff     <= '0;
                  acc_y_ff     <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_x_ff <= req_force_x[FORCE_W-1];
               neg_y_ff <= req_force_y[FORCE_W-1];
            end
         end
         ST_SUM: begin
            neg_x_ff <= vsum_x[VSUM_W-1];
            neg_y_ff <= vsum_y[VSUM_W-1];
            mag_x_ff <= mag_comb_x;
            mag_y_ff <= mag_comb_y;
         end
         ST_SQUARE: begin
            if (!mul_busy_x) begin
               rad_ff  <= SQ_W'(prod_x) + SQ_W'(prod_y);
               rem_ff  <= '0;
               root_ff <= '0;
            end
         end
         ST_ROOT: begin
            if (root_cnt_ff != '0) begin
               rem_ff  <= root_fits ? root_diff[ROOT_W:0] : root_cur[ROOT_W:0];
               root_ff <= {root_ff[ROOT_W-2:0], root_fits};
               rad_ff  <= {rad_ff[SQ_W-3:0], 2'b00};
            end else if (root_done && !root_cap) begin
               vnew_x_ff <= apply_sign(mag_x_ff[VEL_W-1:0], neg_x_ff);
               vnew_y_ff <= apply_sign(mag_y_ff[VEL_W-1:0], neg_y_ff);
            end
         end
         ST_DIVIDE: begin
            if (!div_busy_x) begin
               vnew_x_ff <= apply_sign(VEL_W'(quot_x), neg_x_ff);
               vnew_y_ff <= apply_sign(VEL_W'(quot_y), neg_y_ff);
            end
         end
         ST_MOVE: begin
            if (rsp_free) begin
               bounced_x_ff <= move_x.bounced;
               bounced_y_ff <= move_y.bounced;
            end
         end
         default: begin
         end
      endcase
   end

   // position and velocity state only change together with a new result
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pos_x     = pos_x_ff;
   assign rsp_pos_y     = pos_y_ff;
   assign rsp_vel_x     = vel_x_ff;
   assign rsp_vel_y     = vel_y_ff;
   assign rsp_bounced_x = bounced_x_ff;
   assign rsp_bounced_y = bounced_y_ff;

   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted request did not start the sequencer");

   a_rsp_from_move: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_MOVE)
      else $error("result raised outside the move step");

   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      mul_busy_x == mul_busy_y && div_busy_x == div_busy_y)
      else $error("axis units out of step");

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE && rsp_free) |=> acc_x_ff == '0 && acc_y_ff == '0)
      else $error("acceleration not cleared after a tick");

endmodule
